// ----- rtl/siocr_pkg.sv -----
// Shared constants and types for the super I/O configuration register block.
package siocr_pkg;

	localparam int NUM_DEVICES      = 8;
	localparam int NUM_CONFIG_BYTES = 256;
	localparam int CFG_AW           = $clog2(NUM_CONFIG_BYTES);
	localparam int DEV_W            = $clog2(NUM_DEVICES);

	localparam logic [7:0] KEY_UNLOCK    = 8'hAA;
	localparam logic [7:0] KEY_LOCK      = 8'h55;
	localparam logic [7:0] PNP_CTRL_BYTE = 8'hC1;
	localparam int         PNP_CTRL_BIT  = 7;
	localparam logic [7:0] BYTE_ONES     = 8'hFF;

	localparam logic [7:0] PR_DEVICE  = 8'h07;
	localparam logic [7:0] PR_ENABLE  = 8'h30;
	localparam logic [7:0] PR_ADDR_HI = 8'h60;
	localparam logic [7:0] PR_ADDR_LO = 8'h61;
	localparam logic [7:0] PR_IRQ     = 8'h70;
	localparam logic [7:0] PR_DMA     = 8'h74;

	localparam logic [2:0] PORT_CFG_INDEX = 3'd0;
	localparam logic [2:0] PORT_CFG_DATA  = 3'd1;
	localparam logic [2:0] PORT_PNP_INDEX = 3'd2;
	localparam logic [2:0] PORT_PNP_WDATA = 3'd3;
	localparam logic [2:0] PORT_PNP_RDATA = 3'd4;

	typedef struct packed {
		logic [7:0]  read_data;
		logic        read_claimed;
		logic        pnp_enabled;
		logic        update_valid;
		logic [1:0]  update_device;
		logic        update_enable;
		logic [15:0] update_addr;
		logic [7:0]  update_irq;
	} result_t;

endpackage

// ----- rtl/super_io_config_registers_unit.sv -----
// Top level: super I/O configuration port with plug-and-play register window.
//
//  channel | handshake         | beat contents
//  --------+-------------------+----------------------------------------------
//  in      | in_valid/in_stall | command, port_select, write_data
//  out     | out_valid/out_stall | read_data, read_claimed, pnp_enabled, update_*
//
// One beat in and one result out per cycle while out is not stalled; a beat
// passes the RAM read stage, then the output register. The config byte
// store is a 256x8 RAM with one valid bit per entry, so it reads as zero
// after reset without a clearing pass. Stalls on out back up through the output
// register into the RAM stage; in is stalled only when both stages are full.
module super_io_config_registers_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [2:0]  port_select,
	input  logic [7:0]  write_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  read_data,
	output logic        read_claimed,
	output logic        pnp_enabled,
	output logic        update_valid,
	output logic [1:0]  update_device,
	output logic        update_enable,
	output logic [15:0] update_addr,
	output logic [7:0]  update_irq
);

	localparam int ND = siocr_pkg::NUM_DEVICES;
	localparam int NC = siocr_pkg::NUM_CONFIG_BYTES;

	logic                        lock_q, lock_d;
	logic [7:0]                  cidx_q, cidx_d;
	logic [7:0]                  pidx_q, pidx_d;
	logic [siocr_pkg::DEV_W-1:0] sel_q, sel_d;
	logic                        pnp_en_q, pnp_en_d;
	logic [NC-1:0]               cvalid_q;

	logic [7:0]  dev_en_q   [ND];
	logic [15:0] dev_base_q [ND];
	logic [7:0]  dev_irq_q  [ND];
	logic [7:0]  dev_dma_q  [ND];
	logic [7:0]  dev_en_d   [ND];
	logic [15:0] dev_base_d [ND];
	logic [7:0]  dev_irq_d  [ND];
	logic [7:0]  dev_dma_d  [ND];

	logic                        acc;
	logic                        adv1;
	logic                        ram_we;
	logic                        cfg_rd;
	logic [siocr_pkg::DEV_W-1:0] d;
	logic [7:0]                  pnp_rd;
	logic [7:0]                  ram_rdata;
	siocr_pkg::result_t          res;

	logic                        valid_s1;
	siocr_pkg::result_t          res_s1;
	logic                        cfg_rd_s1;
	logic                        cvalid_s1;
	siocr_pkg::result_t          res_s1_full;

	logic                        valid_q;
	siocr_pkg::result_t          res_q;

	assign adv1     = !valid_q || !out_stall;
	assign in_stall = valid_s1 && !adv1;
	assign acc      = in_valid && !in_stall;
	assign d        = sel_q;

	always_comb begin
		case (pidx_q)
			siocr_pkg::PR_DEVICE:  pnp_rd = {{(8 - siocr_pkg::DEV_W){1'b0}}, d};
			siocr_pkg::PR_ENABLE:  pnp_rd = dev_en_q[d];
			siocr_pkg::PR_ADDR_LO: pnp_rd = dev_base_q[d][7:0];
			siocr_pkg::PR_ADDR_HI: pnp_rd = dev_base_q[d][15:8];
			siocr_pkg::PR_IRQ:     pnp_rd = dev_irq_q[d];
			siocr_pkg::PR_DMA:     pnp_rd = dev_dma_q[d];
			default:               pnp_rd = siocr_pkg::BYTE_ONES;
		endcase
	end

	always_comb begin
		lock_d   = lock_q;
		cidx_d   = cidx_q;
		pidx_d   = pidx_q;
		sel_d    = sel_q;
		pnp_en_d = pnp_en_q;
		ram_we   = 1'b0;
		cfg_rd   = 1'b0;
		for (int i = 0; i < ND; i++) begin
			dev_en_d[i]   = dev_en_q[i];
			dev_base_d[i] = dev_base_q[i];
			dev_irq_d[i]  = dev_irq_q[i];
			dev_dma_d[i]  = dev_dma_q[i];
		end
		res              = '0;
		res.read_data    = command ? siocr_pkg::BYTE_ONES : 8'h00;
		case (port_select)
			siocr_pkg::PORT_CFG_INDEX: begin
				res.read_claimed = 1'b1;
				if (command) begin
					res.read_data = lock_q ? siocr_pkg::BYTE_ONES : cidx_q;
				end else if (lock_q) begin
					if (write_data == siocr_pkg::KEY_UNLOCK) begin
						lock_d = 1'b0;
					end
				end else if (write_data == siocr_pkg::KEY_LOCK) begin
					lock_d = 1'b1;
				end else begin
					cidx_d = write_data;
				end
			end
			siocr_pkg::PORT_CFG_DATA: begin
				res.read_claimed = 1'b1;
				if (command) begin
					cfg_rd = !lock_q;
				end else if (!lock_q) begin
					ram_we = 1'b1;
					if (cidx_q == siocr_pkg::PNP_CTRL_BYTE) begin
						pnp_en_d = write_data[siocr_pkg::PNP_CTRL_BIT];
					end
				end
			end
			siocr_pkg::PORT_PNP_INDEX: begin
				if (pnp_en_q && !command) begin
					res.read_claimed = 1'b1;
					pidx_d           = write_data;
				end
			end
			siocr_pkg::PORT_PNP_WDATA: begin
				if (pnp_en_q && !command) begin
					res.read_claimed = 1'b1;
					if (pidx_q == siocr_pkg::PR_DEVICE) begin
						sel_d = write_data[siocr_pkg::DEV_W-1:0];
					end else begin
						case (pidx_q)
							siocr_pkg::PR_ENABLE:  dev_en_d[d]         = write_data;
							siocr_pkg::PR_ADDR_LO: dev_base_d[d][7:0]  = write_data;
							siocr_pkg::PR_ADDR_HI: dev_base_d[d][15:8] = write_data;
							siocr_pkg::PR_IRQ:     dev_irq_d[d]        = write_data;
							siocr_pkg::PR_DMA:     dev_dma_d[d]        = write_data;
							default:               ;
						endcase
						res.update_valid = !d[siocr_pkg::DEV_W-1];
					end
				end
			end
			siocr_pkg::PORT_PNP_RDATA: begin
				if (pnp_en_q && command) begin
					res.read_claimed = 1'b1;
					res.read_data    = pnp_rd;
				end
			end
			default: ;
		endcase
		res.pnp_enabled = pnp_en_d;
		if (res.update_valid) begin
			res.update_device = d[1:0];
			res.update_enable = dev_en_d[d][0];
			res.update_addr   = dev_base_d[d];
			res.update_irq    = dev_irq_d[d];
		end
	end

	siocr_ram #(
		.WIDTH(8),
		.DEPTH(NC)
	) u_cfg_ram (
		.clk  (clk),
		.we   (acc && ram_we),
		.waddr(cidx_q[siocr_pkg::CFG_AW-1:0]),
		.wdata(write_data),
		.re   (acc && cfg_rd),
		.raddr(cidx_q[siocr_pkg::CFG_AW-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_q   <= 1'b1;
			cidx_q   <= '0;
			pidx_q   <= '0;
			sel_q    <= '0;
			pnp_en_q <= 1'b0;
			cvalid_q <= '0;
			for (int i = 0; i < ND; i++) begin
				dev_en_q[i]   <= '0;
				dev_base_q[i] <= '0;
				dev_irq_q[i]  <= '0;
				dev_dma_q[i]  <= '0;
			end
		end else if (acc) begin
			lock_q   <= lock_d;
			cidx_q   <= cidx_d;
			pidx_q   <= pidx_d;
			sel_q    <= sel_d;
			pnp_en_q <= pnp_en_d;
			if (ram_we) begin
				cvalid_q[cidx_q[siocr_pkg::CFG_AW-1:0]] <= 1'b1;
			end
			for (int i = 0; i < ND; i++) begin
				dev_en_q[i]   <= dev_en_d[i];
				dev_base_q[i] <= dev_base_d[i];
				dev_irq_q[i]  <= dev_irq_d[i];
				dev_dma_q[i]  <= dev_dma_d[i];
			end
		end
	end

	// RAM stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= 1'b1;
		end else if (adv1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			res_s1    <= res;
			cfg_rd_s1 <= cfg_rd;
			cvalid_s1 <= cvalid_q[cidx_q[siocr_pkg::CFG_AW-1:0]];
		end
	end

	always_comb begin
		res_s1_full = res_s1;
		if (cfg_rd_s1) begin
			res_s1_full.read_data = cvalid_s1 ? ram_rdata : 8'h00;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv1) begin
			valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && valid_s1) begin
			res_q <= res_s1_full;
		end
	end

	assign out_valid     = valid_q;
	assign read_data     = res_q.read_data;
	assign read_claimed  = res_q.read_claimed;
	assign pnp_enabled   = res_q.pnp_enabled;
	assign update_valid  = res_q.update_valid;
	assign update_device = res_q.update_device;
	assign update_enable = res_q.update_enable;
	assign update_addr   = res_q.update_addr;
	assign update_irq    = res_q.update_irq;

endmodule

// ----- rtl/siocr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module siocr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
